/* rtl/phong_point_light_shader_unit_defines.svh */
// assertion macros for the shader unit
// both expect clk and rst_n in scope
`ifndef PHONG_POINT_LIGHT_SHADER_UNIT_DEFINES_SVH
`define PHONG_POINT_LIGHT_SHADER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// consequent holds in the same cycle
`define PPLS_CHECK_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shader unit check failed");
// consequent holds in the cycle after the antecedent
`define PPLS_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shader unit check failed");
`else
`define PPLS_CHECK_SAME(lbl, ante, cons)
`define PPLS_CHECK_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/ppls_pkg.sv */
`default_nettype none

package ppls_pkg;

    // direction vector components before normalizing
    localparam int CW   = 18;
    localparam int MW   = CW - 1;
    // squared length, radicand and root
    localparam int SUMW = 2 * MW + 2;
    localparam int RADW = SUMW + 20;
    localparam int LENW = RADW / 2;
    // quotient and numerator of the per-component divide
    localparam int QW   = 16;
    localparam int NUMW = MW + 25;
    // unit vector component, signed q1.14
    localparam int UW   = 16;

    localparam int UNIT_LAT  = 2 + LENW + 1 + QW + 1;
    localparam int SHADE_LAT = 5;
    localparam int CFG_W     = 48;

    localparam logic [15:0] UNIT_ONE       = 16'd16384;
    localparam logic [15:0] Q15_ONE        = 16'd32768;
    localparam logic [15:0] AMBIENT_WEIGHT = 16'd3277;

    typedef logic signed [CW-1:0] comp_t;
    typedef logic signed [UW-1:0] unit_t;

    typedef enum logic [2:0] {
        REG_AMBIENT,
        REG_DIFFUSE,
        REG_SPECULAR,
        REG_SHINE,
        REG_LAMP_POS,
        REG_LAMP_RGB,
        REG_STRENGTH,
        REG_EYE
    } cfg_reg_t;

    // 16-bit lane k of a packed register, lane 0 in the top bits
    function automatic logic [15:0] lane(input logic [47:0] r, input int k);
        logic [47:0] t;
        t = r >> (32 - 16 * k);
        return t[15:0];
    endfunction

    // round q.28 to q.14, half up
    function automatic logic signed [25:0] round14(input logic signed [39:0] x);
        logic signed [39:0] t;
        t = x + 40'sd8192;
        return t[39:14];
    endfunction

    // clamp a dot to 0..1.0 and move it to q1.15
    function automatic logic [15:0] clamp_q15(input logic signed [25:0] d);
        logic [15:0] r;
        if (d < 26'sd0)
            r = '0;
        else if (d > 26'sd16384)
            r = Q15_ONE;
        else
            r = {d[14:0], 1'b0};
        return r;
    endfunction

    // q1.15 product with rounding
    function automatic logic [15:0] mul15(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] p;
        p = 32'(a) * 32'(b) + 32'd16384;
        return p[30:15];
    endfunction

endpackage

`default_nettype wire

/* rtl/ppls_delay.sv */
`default_nettype none

module ppls_delay #(
    parameter int W     = 16,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    output logic [W-1:0] out_data
);

    logic         vld_reg [DEPTH];
    logic [W-1:0] dat_reg [DEPTH];

    // valid line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < DEPTH; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // data line
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dat_reg[0] <= in_data;
            for (int k = 1; k < DEPTH; k++)
                dat_reg[k] <= dat_reg[k-1];
        end
    end

    assign out_valid = vld_reg[DEPTH-1];
    assign out_data  = dat_reg[DEPTH-1];

endmodule

`default_nettype wire

/* rtl/ppls_unitize.sv */
`default_nettype none

module ppls_unitize (
    input  logic            clk,
    input  logic            en,
    input  ppls_pkg::comp_t vec  [3],
    output ppls_pkg::unit_t unit [3]
);

    import ppls_pkg::*;

    localparam int TW  = RADW + 1;
    localparam int DVW = LENW + QW;

    typedef struct packed {
        logic [2:0]          neg;
        logic                zero;
        logic [2:0][MW-1:0]  mag;
    } side_t;

    typedef struct packed {
        logic [RADW-1:0] rem;
        logic [LENW-1:0] root;
        side_t           side;
    } sq_t;

    typedef struct packed {
        logic [2:0]           neg;
        logic                 zero;
        logic [LENW-1:0]      len;
        logic [2:0][NUMW-1:0] rem;
        logic [2:0][QW-1:0]   quo;
    } div_t;

    // one root bit per stage
    function automatic sq_t sqrt_step(input sq_t s, input int b);
        logic [TW-1:0] trial;
        sq_t           r;
        r     = s;
        trial = (TW'(s.root) << (b + 1)) + (TW'(1) << (2 * b));
        if ({1'b0, s.rem} >= trial)
        begin
            r.rem  = s.rem - trial[RADW-1:0];
            r.root = s.root | (LENW'(1) << b);
        end
        return r;
    endfunction

    // one quotient bit per stage, all three components
    function automatic div_t div_step(input div_t s, input int j);
        logic [DVW-1:0] dv;
        div_t           r;
        r  = s;
        dv = DVW'(s.len) << j;
        for (int i = 0; i < 3; i++)
        begin
            if (DVW'(s.rem[i]) >= dv)
            begin
                r.rem[i] = s.rem[i] - dv[NUMW-1:0];
                r.quo[i] = s.quo[i] | (QW'(1) << j);
            end
        end
        return r;
    endfunction

    logic [2:0]           neg_c;
    logic [2:0][MW-1:0]   mag_c;
    logic [2:0][2*MW-1:0] sq_c;
    logic [2:0]           neg0_reg;
    logic [2:0][MW-1:0]   mag0_reg;
    logic [2:0][2*MW-1:0] sq0_reg;
    logic [SUMW-1:0]      sum_c;
    sq_t                  s1_next;
    sq_t                  s1_reg;
    sq_t                  sq_next [LENW];
    sq_t                  sq_reg  [LENW];
    div_t                 prep_next;
    div_t                 prep_reg;
    div_t                 dv_next [QW];
    div_t                 dv_reg  [QW];
    unit_t                unit_next [3];
    unit_t                unit_reg  [3];

    // magnitudes and squares
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            comp_t nv;
            nv       = -vec[i];
            neg_c[i] = vec[i][CW-1];
            mag_c[i] = neg_c[i] ? nv[MW-1:0] : vec[i][MW-1:0];
            sq_c[i]  = (2*MW)'(mag_c[i]) * (2*MW)'(mag_c[i]);
        end
    end

    // squared length, scaled radicand
    always_comb
    begin
        sum_c            = SUMW'(sq0_reg[0]) + SUMW'(sq0_reg[1]) + SUMW'(sq0_reg[2]);
        s1_next.rem      = {sum_c, 20'd0};
        s1_next.root     = '0;
        s1_next.side.neg = neg0_reg;
        s1_next.side.mag = mag0_reg;
        s1_next.side.zero = (sum_c == '0);
    end

    // square root stages
    always_comb
    begin
        sq_next[0] = sqrt_step(s1_reg, LENW - 1);
        for (int k = 1; k < LENW; k++)
            sq_next[k] = sqrt_step(sq_reg[k-1], LENW - 1 - k);
    end

    // divide setup: (m << 24) + len / 2
    always_comb
    begin
        prep_next.neg  = sq_reg[LENW-1].side.neg;
        prep_next.zero = sq_reg[LENW-1].side.zero;
        prep_next.len  = sq_reg[LENW-1].root;
        for (int i = 0; i < 3; i++)
        begin
            prep_next.rem[i] = (NUMW'(sq_reg[LENW-1].side.mag[i]) << 24)
                             + NUMW'(sq_reg[LENW-1].root >> 1);
            prep_next.quo[i] = '0;
        end
    end

    // divide stages
    always_comb
    begin
        dv_next[0] = div_step(prep_reg, QW - 1);
        for (int s = 1; s < QW; s++)
            dv_next[s] = div_step(dv_reg[s-1], QW - 1 - s);
    end

    // clamp and sign
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [QW-1:0] q;
            unit_t         p;
            q = dv_reg[QW-1].quo[i];
            if (q > UNIT_ONE)
                q = UNIT_ONE;
            p = unit_t'(q);
            if (dv_reg[QW-1].zero)
                unit_next[i] = '0;
            else if (dv_reg[QW-1].neg[i])
                unit_next[i] = -p;
            else
                unit_next[i] = p;
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg0_reg <= neg_c;
            mag0_reg <= mag_c;
            sq0_reg  <= sq_c;
            s1_reg   <= s1_next;
            for (int k = 0; k < LENW; k++)
                sq_reg[k] <= sq_next[k];
            prep_reg <= prep_next;
            for (int s = 0; s < QW; s++)
                dv_reg[s] <= dv_next[s];
            for (int i = 0; i < 3; i++)
                unit_reg[i] <= unit_next[i];
        end
    end

    assign unit = unit_reg;

endmodule

`default_nettype wire

/* rtl/ppls_power.sv */
`default_nettype none

module ppls_power #(
    parameter int NB = 8
) (
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] base,
    input  logic [7:0]  expo,
    output logic [15:0] result
);

    import ppls_pkg::*;

    logic [NB-1:0] e_bits;
    logic [15:0]   acc_next [NB];
    logic [15:0]   x_next   [NB];
    logic [15:0]   acc_reg  [NB];
    logic [15:0]   x_reg    [NB];

    // square and multiply, one exponent bit per stage
    always_comb
    begin
        e_bits      = NB'(expo);
        acc_next[0] = e_bits[0] ? mul15(Q15_ONE, base) : Q15_ONE;
        x_next[0]   = mul15(base, base);
        for (int k = 1; k < NB; k++)
        begin
            acc_next[k] = e_bits[k] ? mul15(acc_reg[k-1], x_reg[k-1]) : acc_reg[k-1];
            x_next[k]   = mul15(x_reg[k-1], x_reg[k-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NB; k++)
            begin
                acc_reg[k] <= acc_next[k];
                x_reg[k]   <= x_next[k];
            end
        end
    end

    assign result = acc_reg[NB-1];

endmodule

`default_nettype wire

/* rtl/ppls_shade.sv */
`default_nettype none

module ppls_shade (
    input  logic        clk,
    input  logic        en,
    input  logic [47:0] ambient_rgb,
    input  logic [47:0] diffuse_rgb,
    input  logic [47:0] specular_rgb,
    input  logic [47:0] lamp_rgb,
    input  logic [15:0] lamp_strength,
    input  logic [15:0] diff,
    input  logic [15:0] spec,
    output logic [15:0] colour [3]
);

    import ppls_pkg::*;

    logic [15:0] diff1_reg;
    logic [15:0] spec1_reg;

    // factors follow the first stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff1_reg <= diff;
            spec1_reg <= spec;
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        logic [31:0] kd_lc_reg;
        logic [31:0] ks_lc_reg;
        logic [27:0] amb1_reg;
        logic [27:0] amb2_reg;
        logic [27:0] amb3_reg;
        logic [47:0] pd_reg;
        logic [47:0] ps_reg;
        logic [63:0] td_reg;
        logic [63:0] ts_reg;
        logic [42:0] sum_reg;
        logic [15:0] col_reg;
        logic [64:0] td_rnd;
        logic [64:0] ts_rnd;
        logic [43:0] sum_rnd;
        logic [28:0] val;

        // rounding of terms and of the sum
        always_comb
        begin
            td_rnd  = {1'b0, td_reg} + (65'd1 << 22);
            ts_rnd  = {1'b0, ts_reg} + (65'd1 << 22);
            sum_rnd = {1'b0, sum_reg} + 44'd16384;
            val     = sum_rnd[43:15];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                // reflectance times light colour, ambient weight
                kd_lc_reg <= 32'(lane(diffuse_rgb, c)) * 32'(lane(lamp_rgb, c));
                ks_lc_reg <= 32'(lane(specular_rgb, c)) * 32'(lane(lamp_rgb, c));
                amb1_reg  <= 28'(32'(lane(ambient_rgb, c)) * 32'(AMBIENT_WEIGHT));
                // times geometric factor
                pd_reg    <= 48'(kd_lc_reg) * 48'(diff1_reg);
                ps_reg    <= 48'(ks_lc_reg) * 48'(spec1_reg);
                amb2_reg  <= amb1_reg;
                // times strength
                td_reg    <= 64'(pd_reg) * 64'(lamp_strength);
                ts_reg    <= 64'(ps_reg) * 64'(lamp_strength);
                amb3_reg  <= amb2_reg;
                // q.30 sum
                sum_reg   <= 43'(amb3_reg) + 43'(td_rnd[63:23]) + 43'(ts_rnd[63:23]);
                // q1.15 with saturation
                col_reg   <= (val > 29'(Q15_ONE)) ? Q15_ONE : val[15:0];
            end
        end

        assign colour[c] = col_reg;
    end

endmodule

`default_nettype wire

/* rtl/phong_point_light_shader_unit.sv */
`default_nettype none

// Phong point-light shader: one surface point and normal in, one saturated
// q1.15 rgb word out, one word per clock when the output is not stalled.
// The pipe depth is set mostly by the two chained vector normalizers
// (squared length, a bit-per-stage root and a bit-per-stage divide)
// plus one stage per exponent bit of the power.
// The whole pipe advances together; a stalled result parks in a one-word
// output register and in_stall rises on the following cycle until it is
// taken. Configuration is written through cfg_we/cfg_index/cfg_data and
// must only change while no word is in flight.
module phong_point_light_shader_unit #(
    parameter int SHININESS_BITS = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [2:0]               cfg_index,
    input  logic [ppls_pkg::CFG_W-1:0] cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [15:0]       point_x,
    input  logic signed [15:0]       point_y,
    input  logic signed [15:0]       point_z,
    input  logic signed [15:0]       normal_x,
    input  logic signed [15:0]       normal_y,
    input  logic signed [15:0]       normal_z,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [15:0]              red_out,
    output logic [15:0]              green_out,
    output logic [15:0]              blue_out
);

    import ppls_pkg::*;

    `include "phong_point_light_shader_unit_defines.svh"

    localparam int DW  = 18;
    localparam int RPW = 36;
    localparam int SBW = 3 * UW + 16;

    // configuration registers
    logic [47:0] ambient_reg;
    logic [47:0] diffuse_reg;
    logic [47:0] specular_reg;
    logic [7:0]  shine_reg;
    logic [47:0] lamp_pos_reg;
    logic [47:0] lamp_rgb_reg;
    logic [15:0] strength_reg;
    logic [47:0] eye_reg;

    logic        en;
    logic signed [15:0] pts [3];
    logic signed [15:0] nrm [3];

    comp_t lv_reg [3];
    comp_t vv_reg [3];
    comp_t nv_reg [3];
    logic  v0_reg;
    logic  vl_reg [UNIT_LAT];

    unit_t lu [3];
    unit_t nu [3];
    unit_t vu [3];

    logic signed [31:0]   nl_prod_reg [3];
    unit_t                nu1_reg [3];
    unit_t                lu1_reg [3];
    unit_t                vu1_reg [3];
    logic                 v1_reg;
    logic signed [DW-1:0] d_reg;
    logic signed [25:0]   d_rnd;
    unit_t                nu2_reg [3];
    unit_t                lu2_reg [3];
    unit_t                vu2_reg [3];
    logic                 v2_reg;
    logic signed [RPW-1:0] rp_reg [3];
    unit_t                lu3_reg [3];
    unit_t                vu3_reg [3];
    logic [15:0]          diff3_reg;
    logic                 v3_reg;
    comp_t                rv_reg [3];
    unit_t                vu4_reg [3];
    logic [15:0]          diff4_reg;
    logic                 v4_reg;

    logic [SBW-1:0]       sb_in;
    logic [SBW-1:0]       sb_out;
    logic                 v5;
    unit_t                ru [3];
    unit_t                vu5 [3];

    logic signed [31:0]   vr_prod_reg [3];
    logic [15:0]          diff6_reg;
    logic                 v6_reg;
    logic [15:0]          base_reg;
    logic [15:0]          diff7_reg;
    logic                 v7_reg;

    logic [15:0]          spec_pow;
    logic [15:0]          diff8;
    logic                 v8;
    logic                 vs_reg [SHADE_LAT];
    logic [15:0]          last_col [3];
    logic                 last_valid;
    logic                 skid_full_reg;
    logic [15:0]          skid_col_reg [3];

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ambient_reg  <= '0;
            diffuse_reg  <= '0;
            specular_reg <= '0;
            shine_reg    <= 8'd1;
            lamp_pos_reg <= '0;
            lamp_rgb_reg <= '0;
            strength_reg <= 16'd256;
            eye_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_AMBIENT:  ambient_reg  <= cfg_data;
                REG_DIFFUSE:  diffuse_reg  <= cfg_data;
                REG_SPECULAR: specular_reg <= cfg_data;
                REG_SHINE:    shine_reg    <= cfg_data[7:0];
                REG_LAMP_POS: lamp_pos_reg <= cfg_data;
                REG_LAMP_RGB: lamp_rgb_reg <= cfg_data;
                REG_STRENGTH: strength_reg <= cfg_data[15:0];
                REG_EYE:      eye_reg      <= cfg_data;
                default:      ;
            endcase
        end
    end

    // the pipe advances unless a word waits in the skid register
    assign en       = !skid_full_reg;
    assign in_stall = skid_full_reg;

    always_comb
    begin
        pts[0] = point_x;
        pts[1] = point_y;
        pts[2] = point_z;
        nrm[0] = normal_x;
        nrm[1] = normal_y;
        nrm[2] = normal_z;
    end

    // light and view vectors
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                lv_reg[i] <= CW'($signed(lane(lamp_pos_reg, i))) - CW'(pts[i]);
                vv_reg[i] <= CW'($signed(lane(eye_reg, i))) - CW'(pts[i]);
                nv_reg[i] <= CW'(nrm[i]);
            end
        end
    end

    ppls_unitize u_unit_l (.clk(clk), .en(en), .vec(lv_reg), .unit(lu));
    ppls_unitize u_unit_n (.clk(clk), .en(en), .vec(nv_reg), .unit(nu));
    ppls_unitize u_unit_v (.clk(clk), .en(en), .vec(vv_reg), .unit(vu));

    // valid bits of both halves of the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            for (int k = 0; k < UNIT_LAT; k++)
                vl_reg[k] <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            for (int k = 0; k < SHADE_LAT; k++)
                vs_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            v0_reg    <= in_valid;
            vl_reg[0] <= v0_reg;
            for (int k = 1; k < UNIT_LAT; k++)
                vl_reg[k] <= vl_reg[k-1];
            v1_reg    <= vl_reg[UNIT_LAT-1];
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v6_reg    <= v5;
            v7_reg    <= v6_reg;
            vs_reg[0] <= v8;
            for (int k = 1; k < SHADE_LAT; k++)
                vs_reg[k] <= vs_reg[k-1];
        end
    end

    always_comb
    begin
        d_rnd = round14(40'(nl_prod_reg[0]) + 40'(nl_prod_reg[1]) + 40'(nl_prod_reg[2]));
    end

    // n.l, reflection vector
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic signed [25:0] r14;
                r14 = round14(40'(rp_reg[i]));
                nl_prod_reg[i] <= 32'(nu[i]) * 32'(lu[i]);
                nu1_reg[i]     <= nu[i];
                lu1_reg[i]     <= lu[i];
                vu1_reg[i]     <= vu[i];
                nu2_reg[i]     <= nu1_reg[i];
                lu2_reg[i]     <= lu1_reg[i];
                vu2_reg[i]     <= vu1_reg[i];
                rp_reg[i]      <= (RPW'(d_reg) * RPW'(nu2_reg[i])) <<< 1;
                lu3_reg[i]     <= lu2_reg[i];
                vu3_reg[i]     <= vu2_reg[i];
                rv_reg[i]      <= comp_t'(r14[CW-1:0]) - CW'(lu3_reg[i]);
                vu4_reg[i]     <= vu3_reg[i];
            end
            d_reg     <= d_rnd[DW-1:0];
            diff3_reg <= clamp_q15(26'(d_reg));
            diff4_reg <= diff3_reg;
        end
    end

    // reflection normalize, view vector and diffuse factor ride alongside
    assign sb_in = {vu4_reg[0], vu4_reg[1], vu4_reg[2], diff4_reg};

    ppls_unitize u_unit_r (.clk(clk), .en(en), .vec(rv_reg), .unit(ru));

    ppls_delay #(
        .W     (SBW),
        .DEPTH (UNIT_LAT)
    ) u_side_r (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v4_reg),
        .in_data   (sb_in),
        .out_valid (v5),
        .out_data  (sb_out)
    );

    always_comb
    begin
        vu5[0] = sb_out[SBW-1 -: UW];
        vu5[1] = sb_out[SBW-1-UW -: UW];
        vu5[2] = sb_out[SBW-1-2*UW -: UW];
    end

    // v.r and specular base
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                vr_prod_reg[i] <= 32'(vu5[i]) * 32'(ru[i]);
            diff6_reg <= sb_out[15:0];
            base_reg  <= clamp_q15(round14(40'(vr_prod_reg[0]) + 40'(vr_prod_reg[1])
                                           + 40'(vr_prod_reg[2])));
            diff7_reg <= diff6_reg;
        end
    end

    ppls_power #(
        .NB (SHININESS_BITS)
    ) u_power (
        .clk    (clk),
        .en     (en),
        .base   (base_reg),
        .expo   (shine_reg),
        .result (spec_pow)
    );

    ppls_delay #(
        .W     (16),
        .DEPTH (SHININESS_BITS)
    ) u_side_p (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .in_data   (diff7_reg),
        .out_valid (v8),
        .out_data  (diff8)
    );

    ppls_shade u_shade (
        .clk           (clk),
        .en            (en),
        .ambient_rgb   (ambient_reg),
        .diffuse_rgb   (diffuse_reg),
        .specular_rgb  (specular_reg),
        .lamp_rgb      (lamp_rgb_reg),
        .lamp_strength (strength_reg),
        .diff          (diff8),
        .spec          (spec_pow),
        .colour        (last_col)
    );

    assign last_valid = vs_reg[SHADE_LAT-1];

    // skid register for a stalled word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_full_reg <= 1'b0;
        else if (skid_full_reg)
            skid_full_reg <= out_stall;
        else
            skid_full_reg <= last_valid && out_stall;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                skid_col_reg[i] <= last_col[i];
        end
    end

    // output word
    assign out_valid = skid_full_reg || last_valid;
    assign red_out   = skid_full_reg ? skid_col_reg[0] : last_col[0];
    assign green_out = skid_full_reg ? skid_col_reg[1] : last_col[1];
    assign blue_out  = skid_full_reg ? skid_col_reg[2] : last_col[2];

    `PPLS_CHECK_NEXT(a_skid_drain, skid_full_reg && !out_stall, !skid_full_reg)
    `PPLS_CHECK_NEXT(a_skid_catch, !skid_full_reg && last_valid && out_stall, skid_full_reg && skid_col_reg[0] == $past(last_col[0]))
    `PPLS_CHECK_SAME(a_saturate, out_valid, red_out <= Q15_ONE && green_out <= Q15_ONE && blue_out <= Q15_ONE)

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    import ppls_pkg::*;

    localparam int SHINE_BITS = 8;
    localparam int PIPE_LAT   = 108 + SHINE_BITS;
    localparam int CYC_LIMIT  = 300000;

    typedef struct packed {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } surf_word_t;

    typedef struct packed {
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
    } color_word_t;

    typedef logic [2:0][63:0] v3_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [2:0]        cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic signed [15:0] point_x, point_y, point_z;
    logic signed [15:0] normal_x, normal_y, normal_z;
    logic              out_valid;
    logic              out_stall;
    logic [15:0]       red_out, green_out, blue_out;

    // material and light settings as the block holds them
    logic [47:0] amb_rgb, dif_rgb, spc_rgb, lamp_pos, lamp_col, eye_pos;
    logic [7:0]  shine;
    logic [15:0] strength;

    surf_word_t  pend_q[$];
    color_word_t color_q[$];
    int          fails;
    int          cycles;
    bit          calm;
    int          in_gap;
    int          out_gap;

    phong_point_light_shader_unit #(.SHININESS_BITS(SHINE_BITS)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .red_out(red_out), .green_out(green_out), .blue_out(blue_out)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // integer square root, bit by bit
    function automatic longint unsigned isqrt_u64(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // floor((v + 2^13) / 2^14)
    function automatic longint rnd14(input longint v);
        return (v + 64'sd8192) >>> 14;
    endfunction

    // scale to unit length in q1.14, zero stays zero
    function automatic v3_t unit_vec(input v3_t c);
        v3_t u;
        longint ci;
        longint unsigned m, s, len, q;
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            ci = signed'(c[i]);
            m = (ci < 0) ? -ci : ci;
            s = s + m * m;
        end
        u = '0;
        if (s != 0)
        begin
            len = isqrt_u64(s << 20);
            for (int i = 0; i < 3; i++)
            begin
                ci = signed'(c[i]);
                m = (ci < 0) ? -ci : ci;
                q = ((m << 24) + len / 2) / len;
                if (q > 16384)
                    q = 16384;
                u[i] = (ci < 0) ? -longint'(q) : longint'(q);
            end
        end
        return u;
    endfunction

    function automatic longint dot_u(input v3_t a, input v3_t b);
        return rnd14(signed'(a[0]) * signed'(b[0]) + signed'(a[1]) * signed'(b[1])
                     + signed'(a[2]) * signed'(b[2]));
    endfunction

    // clamp a dot to 0..1.0, result in q1.15
    function automatic longint unsigned sat_dot(input longint d);
        if (d < 0)
            d = 0;
        if (d > 16384)
            d = 16384;
        return longint'(d) << 1;
    endfunction

    function automatic longint unsigned qmul(input longint unsigned a,
                                             input longint unsigned b);
        return (a * b + 16384) >> 15;
    endfunction

    // square-and-multiply power over the low exponent bits
    function automatic longint unsigned raise_pow(input longint unsigned x,
                                                  input logic [7:0] e);
        longint unsigned acc;
        acc = 32768;
        for (int i = 0; i < SHINE_BITS; i++)
        begin
            if (e[i])
                acc = qmul(acc, x);
            x = qmul(x, x);
        end
        return acc;
    endfunction

    function automatic logic [15:0] lane_of(input logic [47:0] r, input int k);
        return r[47 - 16 * k -: 16];
    endfunction

    // phong color of one surface point under the current settings
    function automatic color_word_t shade_point(input surf_word_t w);
        v3_t lv, nv, vv, rv, lu, nu, vu, ru;
        longint d, p;
        longint unsigned dif, spc, sum, prod, lc;
        logic [15:0] ch[3];
        for (int i = 0; i < 3; i++)
        begin
            p = (i == 0) ? longint'(w.px) : (i == 1) ? longint'(w.py) : longint'(w.pz);
            lv[i] = longint'(signed'(lane_of(lamp_pos, i))) - p;
            vv[i] = longint'(signed'(lane_of(eye_pos, i))) - p;
            nv[i] = (i == 0) ? longint'(w.nx) : (i == 1) ? longint'(w.ny) : longint'(w.nz);
        end
        lu = unit_vec(lv);
        nu = unit_vec(nv);
        vu = unit_vec(vv);
        d = dot_u(nu, lu);
        for (int i = 0; i < 3; i++)
            rv[i] = rnd14(2 * d * signed'(nu[i])) - signed'(lu[i]);
        ru = unit_vec(rv);
        dif = sat_dot(d);
        spc = raise_pow(sat_dot(dot_u(vu, ru)), shine);
        for (int i = 0; i < 3; i++)
        begin
            lc = 64'(lane_of(lamp_col, i));
            sum = longint'(lane_of(amb_rgb, i)) * 3277;
            prod = longint'(lane_of(dif_rgb, i)) * lc * dif * 64'(strength);
            sum = sum + ((prod + (64'd1 << 22)) >> 23);
            prod = longint'(lane_of(spc_rgb, i)) * lc * spc * 64'(strength);
            sum = sum + ((prod + (64'd1 << 22)) >> 23);
            sum = (sum + 16384) >> 15;
            if (sum > 32768)
                sum = 32768;
            ch[i] = sum[15:0];
        end
        return '{r: ch[0], g: ch[1], b: ch[2]};
    endfunction

    // input driver with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        surf_word_t nxt;
        logic       v;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            point_x <= '0; point_y <= '0; point_z <= '0;
            normal_x <= '0; normal_y <= '0; normal_z <= '0;
            in_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                color_q.push_back(shade_point(pend_q[0]));
                void'(pend_q.pop_front());
            end
            if (!(in_valid && in_stall))
            begin
                v = 1'b0;
                nxt = '0;
                if (in_gap > 0)
                    in_gap--;
                else if (!calm && $urandom_range(0, 9) == 0)
                    in_gap = $urandom_range(1, 11) - 1;
                else if (pend_q.size() != 0)
                begin
                    v = 1'b1;
                    nxt = pend_q[0];
                end
                in_valid <= v;
                point_x <= nxt.px; point_y <= nxt.py; point_z <= nxt.pz;
                normal_x <= nxt.nx; normal_y <= nxt.ny; normal_z <= nxt.nz;
            end
        end
    end

    // output stall bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap = 0;
        end
        else if (calm)
            out_stall <= 1'b0;
        else if (out_gap > 0)
        begin
            out_gap--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            out_gap = $urandom_range(1, 11) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // result checker
    always @(posedge clk)
    begin
        color_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (color_q.size() == 0)
            begin
                fails++;
                if (fails <= 10)
                    $display("unexpected word r=%0d g=%0d b=%0d", red_out, green_out, blue_out);
            end
            else
            begin
                want = color_q.pop_front();
                if (want.r !== red_out || want.g !== green_out || want.b !== blue_out)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("mismatch: expected r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                                 want.r, want.g, want.b, red_out, green_out, blue_out);
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYC_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic set_reg(input cfg_reg_t idx, input logic [47:0] val);
        case (idx)
            REG_AMBIENT:  amb_rgb = val;
            REG_DIFFUSE:  dif_rgb = val;
            REG_SPECULAR: spc_rgb = val;
            REG_SHINE:    shine = val[7:0];
            REG_LAMP_POS: lamp_pos = val;
            REG_LAMP_RGB: lamp_col = val;
            REG_STRENGTH: strength = val[15:0];
            default:      eye_pos = val;
        endcase
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait for every word to come back, then let the pipe empty
    task automatic drain();
        while (pend_q.size() != 0 || color_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 10) @(posedge clk);
    endtask

    function automatic logic [47:0] rand_col(input bit wild);
        logic [47:0] c;
        for (int i = 0; i < 3; i++)
            c[16 * i +: 16] = wild ? 16'($urandom) : 16'($urandom_range(0, 32768));
        return c;
    endfunction

    function automatic logic [47:0] rand_pos(input bit wild);
        logic [47:0] c;
        for (int i = 0; i < 3; i++)
            c[16 * i +: 16] = wild ? 16'($urandom) : 16'($urandom_range(0, 8192) - 4096);
        return c;
    endfunction

    function automatic surf_word_t rand_surf(input bit wild);
        surf_word_t w;
        if (wild)
            w = {$urandom, $urandom, $urandom};
        else
        begin
            w.px = 16'($urandom_range(0, 4096) - 2048);
            w.py = 16'($urandom_range(0, 4096) - 2048);
            w.pz = 16'($urandom_range(0, 4096) - 2048);
            w.nx = 16'($urandom_range(0, 32768) - 16384);
            w.ny = 16'($urandom_range(0, 32768) - 16384);
            w.nz = 16'($urandom_range(0, 32768) - 16384);
        end
        return w;
    endfunction

    function automatic surf_word_t mk(input int px, py, pz, nx, ny, nz);
        return '{px: 16'(px), py: 16'(py), pz: 16'(pz), nx: 16'(nx), ny: 16'(ny), nz: 16'(nz)};
    endfunction

    // stimulus and phase control
    initial
    begin
        fails = 0;
        cycles = 0;
        calm = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        amb_rgb = '0; dif_rgb = '0; spc_rgb = '0; lamp_pos = '0;
        lamp_col = '0; eye_pos = '0; shine = 8'd1; strength = 16'd256;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // defaults after reset
        for (int i = 0; i < 4; i++)
            pend_q.push_back(rand_surf(1'b0));
        drain();

        // directed: plain scene, lamp and eye above the origin
        set_reg(REG_AMBIENT, {16'd32768, 16'd16384, 16'd0});
        set_reg(REG_DIFFUSE, {16'd32768, 16'd20000, 16'd65535});
        set_reg(REG_SPECULAR, {16'd32768, 16'd32768, 16'd10000});
        set_reg(REG_SHINE, 48'd8);
        set_reg(REG_LAMP_POS, {16'sd512, 16'sd0, 16'sd2560});
        set_reg(REG_LAMP_RGB, {16'd32768, 16'd32768, 16'd32768});
        set_reg(REG_STRENGTH, 48'd256);
        set_reg(REG_EYE, {16'sd0, 16'sd256, 16'sd1280});
        pend_q.push_back(mk(0, 0, 0, 0, 0, 16384));
        pend_q.push_back(mk(0, 0, 0, 0, 0, 0));
        pend_q.push_back(mk(512, 0, 2560, 0, 0, 16384));
        pend_q.push_back(mk(0, 256, 1280, 0, 16384, 0));
        pend_q.push_back(mk(0, 0, 0, 0, 0, -16384));
        pend_q.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768));
        pend_q.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767));
        pend_q.push_back(mk(-32768, 32767, 0, 32767, -32768, 0));
        pend_q.push_back(mk(100, -200, 300, 1, 0, 0));
        pend_q.push_back(mk(0, 0, 0, 8000, 8000, 8000));
        pend_q.push_back(mk(-1, -1, -1, -1, -1, -1));
        pend_q.push_back(mk(0, 0, -2560, 16384, 16384, 0));
        drain();

        // zero exponent, maximum strength, reflectances above 1.0
        set_reg(REG_SHINE, 48'd0);
        set_reg(REG_STRENGTH, 48'hFFFF);
        set_reg(REG_AMBIENT, 48'hFFFF_FFFF_FFFF);
        pend_q.push_back(mk(0, 0, 0, 0, 0, 16384));
        pend_q.push_back(mk(0, 0, 0, 0, 0, -16384));
        pend_q.push_back(mk(512, 0, 2560, 0, 0, 0));
        drain();

        // highest exponent, zero strength, all-ones registers
        set_reg(REG_SHINE, 48'd255);
        set_reg(REG_STRENGTH, 48'd0);
        set_reg(REG_DIFFUSE, 48'hFFFF_FFFF_FFFF);
        set_reg(REG_SPECULAR, 48'hFFFF_FFFF_FFFF);
        set_reg(REG_LAMP_RGB, 48'hFFFF_FFFF_FFFF);
        set_reg(REG_LAMP_POS, 48'hFFFF_FFFF_FFFF);
        set_reg(REG_EYE, 48'h8000_7FFF_8000);
        set_reg(REG_AMBIENT, 48'h0);
        pend_q.push_back(mk(0, 0, 0, 0, 0, 16384));
        pend_q.push_back(mk(-1, -1, -1, 100, 200, 300));
        pend_q.push_back(mk(-32768, 32767, -32768, 16384, 0, 0));
        drain();

        // random phases, the last one without idling
        for (int ph = 0; ph < 8; ph++)
        begin
            set_reg(REG_AMBIENT, rand_col(ph % 4 == 3));
            set_reg(REG_DIFFUSE, rand_col(ph % 4 == 2));
            set_reg(REG_SPECULAR, rand_col(ph % 4 == 1));
            set_reg(REG_SHINE, 48'((ph == 0) ? 8'd1 : 8'($urandom_range(0, 255))));
            set_reg(REG_LAMP_POS, rand_pos(ph == 5));
            set_reg(REG_LAMP_RGB, rand_col(ph % 3 == 2));
            set_reg(REG_STRENGTH,
                    48'((ph % 3 == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024))));
            set_reg(REG_EYE, rand_pos(ph == 6));
            if (ph == 7)
                calm = 1'b1;
            for (int i = 0; i < 50; i++)
                pend_q.push_back(rand_surf($urandom_range(0, 4) == 0));
            drain();
        end

        if (fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
